// ----- design/lwvo_pkg.sv -----
`timescale 1ns / 1ps

package lwvo_pkg;

    localparam int OPERATION_W = 2;
    localparam int ADDRESS_W   = 16;
    localparam int DATA_W      = 16;
    localparam int STEP_W      = 19;
    localparam int FRAC_W      = 16;
    localparam int PHASE_SUM_W = 20;
    localparam int WHOLE_W     = PHASE_SUM_W - FRAC_W;
    localparam int PLAY_W      = 18;
    localparam int INDEX_W     = 19;
    localparam int COEF_W      = 14;
    localparam int DIFF_W      = DATA_W + 1;
    localparam int PROD_W      = COEF_W + DIFF_W;
    localparam int ACC_W       = 33;
    localparam int COEF_SHIFT  = 12;
    localparam int QUOT_W      = ACC_W - COEF_SHIFT;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int LEN_W       = 16;
    localparam int COUNT_W     = 17;

    localparam logic [OPERATION_W-1:0] OP_WR_SAMPLE = 2'd0;
    localparam logic [OPERATION_W-1:0] OP_WR_COEF   = 2'd1;
    localparam logic [OPERATION_W-1:0] OP_TICK      = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_LENGTH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PING_PONG     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_COUNT  = 2'd3;

    localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = 17'h10000;

    localparam logic signed [QUOT_W-1:0] SAT_HIGH = 21'sd32767;
    localparam logic signed [QUOT_W-1:0] SAT_LOW  = -21'sd32768;
    localparam logic [ACC_W-1:0] ROUND_BIAS = 33'd4095;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_ADV,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic       wr_sample;
        logic       wr_coef;
        logic       start_tick;
        logic       issue_rd;
        logic       coef_rd;
        logic [1:0] coef_sel;
        logic       capture;
        logic [1:0] cap_sel;
        logic       accum;
        logic       finish;
        logic       advance;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic whole_zero;
        logic out_free;
    } status_t;

endpackage

// ----- design/lwvo_ifs.sv -----
`timescale 1ns / 1ps

interface lwvo_item_if;
    logic                                    valid;
    logic                                    ready;
    logic [lwvo_pkg::OPERATION_W-1:0]        operation;
    logic [lwvo_pkg::ADDRESS_W-1:0]          address;
    logic signed [lwvo_pkg::DATA_W-1:0]      write_data;
    logic [lwvo_pkg::STEP_W-1:0]             phase_step;

    modport source (output valid, operation, address, write_data, phase_step, input ready);
    modport sink (input valid, operation, address, write_data, phase_step, output ready);
endinterface

interface lwvo_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [lwvo_pkg::DATA_W-1:0] sample_out;
    logic                               first_run_done;

    modport source (output valid, sample_out, first_run_done, input ready);
    modport sink (input valid, sample_out, first_run_done, output ready);
endinterface

// ----- design/lwvo_ctrl.sv -----
`timescale 1ns / 1ps

module lwvo_ctrl
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    input  logic [lwvo_pkg::OPERATION_W-1:0] operation,
    output logic                             item_ready,
    output lwvo_pkg::cmd_t                   cmd,
    input  lwvo_pkg::status_t                status
);

    localparam logic [2:0] MAC_LAST = 3'd6;

    lwvo_pkg::ctrl_state_t state_reg;
    lwvo_pkg::ctrl_state_t state_next;
    logic [2:0]            cnt_reg;
    logic [2:0]            cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lwvo_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        item_ready = 1'b0;
        cmd        = '0;
        case (state_reg)
            lwvo_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    case (operation)
                        lwvo_pkg::OP_WR_SAMPLE: cmd.wr_sample = 1'b1;
                        lwvo_pkg::OP_WR_COEF:   cmd.wr_coef = 1'b1;
                        lwvo_pkg::OP_TICK:
                        begin
                            cmd.start_tick = 1'b1;
                            cnt_next       = '0;
                            state_next     = lwvo_pkg::ST_MAC;
                        end
                        default: ;
                    endcase
                end
            end
            lwvo_pkg::ST_MAC:
            begin
                // tap reads, coefficient reads, products and sums overlap
                cmd.issue_rd = cnt_reg inside {[3'd0:3'd3]};
                cmd.coef_rd  = cnt_reg inside {[3'd1:3'd3]};
                cmd.coef_sel = 2'(cnt_reg - 3'd1);
                cmd.capture  = cnt_reg inside {[3'd1:3'd4]};
                cmd.cap_sel  = 2'(cnt_reg - 3'd1);
                cmd.accum    = cnt_reg inside {[3'd3:3'd5]};
                cnt_next     = cnt_reg + 3'd1;
                if (cnt_reg == MAC_LAST)
                begin
                    cmd.finish = 1'b1;
                    state_next = lwvo_pkg::ST_ADV;
                end
            end
            lwvo_pkg::ST_ADV:
            begin
                if (status.whole_zero)
                    state_next = lwvo_pkg::ST_EMIT;
                else
                    cmd.advance = 1'b1;
            end
            lwvo_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = lwvo_pkg::ST_IDLE;
                end
            end
            default: state_next = lwvo_pkg::ST_IDLE;
        endcase
    end

endmodule

// ----- design/lwvo_datapath.sv -----
`timescale 1ns / 1ps

module lwvo_datapath #(
    parameter int SAMPLE_ADDR_BITS = 16,
    parameter int INTERP_STEPS     = 128
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [lwvo_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [lwvo_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic [lwvo_pkg::ADDRESS_W-1:0]          address,
    input  logic signed [lwvo_pkg::DATA_W-1:0]      write_data,
    input  logic [lwvo_pkg::STEP_W-1:0]             phase_step,
    input  lwvo_pkg::cmd_t                          cmd,
    output lwvo_pkg::status_t                       status,
    output logic                                    result_valid,
    input  logic                                    result_ready,
    output logic signed [lwvo_pkg::DATA_W-1:0]      sample_out,
    output logic                                    first_run_done
);

    localparam int DEPTH      = 1 << SAMPLE_ADDR_BITS;
    localparam int COEF_DEPTH = 3 * INTERP_STEPS;
    localparam int CAW        = $clog2(COEF_DEPTH);
    localparam int RW         = $clog2(INTERP_STEPS);
    localparam int PW         = lwvo_pkg::FRAC_W + RW;
    localparam int CW         = ((SAMPLE_ADDR_BITS > lwvo_pkg::COUNT_W) ?
                                 SAMPLE_ADDR_BITS : lwvo_pkg::COUNT_W) + 2;
    localparam int IW         = lwvo_pkg::INDEX_W;

    function automatic logic signed [IW-1:0] step_index(
        input logic signed [IW-1:0] i,
        input logic signed [IW-1:0] e,
        input logic signed [IW-1:0] s
    );
        logic signed [IW-1:0] inc;
        inc = i + $signed(IW'(1));
        return (inc > e) ? s : inc;
    endfunction

    // configuration
    logic [lwvo_pkg::LEN_W-1:0]   sample_length_reg;
    logic [lwvo_pkg::LEN_W-1:0]   loop_length_reg;
    logic                         ping_pong_reg;
    logic [lwvo_pkg::COUNT_W-1:0] sample_count_reg;

    // stores
    logic signed [lwvo_pkg::DATA_W-1:0] sample_mem [DEPTH];
    logic signed [lwvo_pkg::COEF_W-1:0] coef_mem [COEF_DEPTH];
    logic signed [lwvo_pkg::DATA_W-1:0] rd_data_reg;
    logic signed [lwvo_pkg::COEF_W-1:0] coef_data_reg;

    // voice state
    logic [lwvo_pkg::FRAC_W-1:0]  phase_reg;
    logic [lwvo_pkg::PLAY_W-1:0]  play_index_reg;
    logic                         first_seen_reg;

    // per-tick working registers
    logic signed [IW-1:0]               e_reg;
    logic signed [IW-1:0]               s_reg;
    logic signed [IW-1:0]               walk_reg;
    logic [SAMPLE_ADDR_BITS-1:0]        lim_reg;
    logic [RW-1:0]                      row_reg;
    logic [lwvo_pkg::WHOLE_W-1:0]       whole_reg;
    logic                               flag_reg;
    logic signed [lwvo_pkg::DATA_W-1:0] prev_reg;
    logic signed [lwvo_pkg::PROD_W-1:0] prod_reg;
    logic signed [lwvo_pkg::ACC_W-1:0]  acc_reg;
    logic signed [lwvo_pkg::DATA_W-1:0] q_reg;

    // output register
    logic                               out_valid_reg;
    logic signed [lwvo_pkg::DATA_W-1:0] sample_out_reg;
    logic                               flag_out_reg;

    logic signed [IW-1:0]                   len_ext;
    logic signed [IW-1:0]                   loop_ext;
    logic signed [IW-1:0]                   e_calc;
    logic signed [IW-1:0]                   s_calc;
    logic [CW-1:0]                          count_ext;
    logic [CW-1:0]                          n_calc;
    logic [CW-1:0]                          lim_calc;
    logic [PW-1:0]                          row_prod;
    logic [lwvo_pkg::PHASE_SUM_W-1:0]       phase_sum;
    logic signed [CW-1:0]                   walk_ext;
    logic [SAMPLE_ADDR_BITS-1:0]            rd_addr;
    logic [CAW-1:0]                         coef_base;
    logic [CAW-1:0]                         coef_addr;
    logic signed [lwvo_pkg::DIFF_W-1:0]     diff;
    logic signed [lwvo_pkg::ACC_W-1:0]      acc_adj;
    logic signed [lwvo_pkg::QUOT_W-1:0]     quot;
    logic signed [lwvo_pkg::DATA_W-1:0]     q_sat;
    logic signed [IW-1:0]                   play_ext;

    always_comb
    begin
        len_ext  = $signed(IW'(sample_length_reg));
        loop_ext = $signed(IW'(loop_length_reg));
        e_calc   = ping_pong_reg ? (len_ext + loop_ext + $signed(IW'(1))) : len_ext;
        s_calc   = len_ext - loop_ext;

        count_ext = CW'(sample_count_reg);
        if (count_ext == '0)
            n_calc = CW'(1);
        else if (count_ext > CW'(DEPTH))
            n_calc = CW'(DEPTH);
        else
            n_calc = count_ext;
        lim_calc = n_calc - CW'(1);

        row_prod  = PW'(phase_reg) * PW'(INTERP_STEPS);
        phase_sum = lwvo_pkg::PHASE_SUM_W'(phase_reg) + lwvo_pkg::PHASE_SUM_W'(phase_step);

        walk_ext = {{(CW - IW){walk_reg[IW-1]}}, walk_reg};
        if (walk_ext[CW-1])
            rd_addr = '0;
        else if (walk_ext > $signed(CW'(lim_reg)))
            rd_addr = lim_reg;
        else
            rd_addr = walk_ext[SAMPLE_ADDR_BITS-1:0];

        case (cmd.coef_sel)
            2'd0:    coef_base = '0;
            2'd1:    coef_base = CAW'(INTERP_STEPS);
            2'd2:    coef_base = CAW'(2 * INTERP_STEPS);
            default: coef_base = '0;
        endcase
        coef_addr = coef_base + CAW'(row_reg);

        diff = {rd_data_reg[lwvo_pkg::DATA_W-1], rd_data_reg}
             - {prev_reg[lwvo_pkg::DATA_W-1], prev_reg};

        // truncate toward zero
        acc_adj = acc_reg + (acc_reg[lwvo_pkg::ACC_W-1] ? $signed(lwvo_pkg::ROUND_BIAS) :
                                                          $signed(lwvo_pkg::ACC_W'(0)));
        quot = acc_adj[lwvo_pkg::ACC_W-1:lwvo_pkg::COEF_SHIFT];
        if (quot > lwvo_pkg::SAT_HIGH)
            q_sat = lwvo_pkg::SAT_HIGH[lwvo_pkg::DATA_W-1:0];
        else if (quot < lwvo_pkg::SAT_LOW)
            q_sat = lwvo_pkg::SAT_LOW[lwvo_pkg::DATA_W-1:0];
        else
            q_sat = quot[lwvo_pkg::DATA_W-1:0];

        play_ext = {play_index_reg[lwvo_pkg::PLAY_W-1], play_index_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_length_reg <= '0;
            loop_length_reg   <= '0;
            ping_pong_reg     <= 1'b0;
            sample_count_reg  <= lwvo_pkg::SAMPLE_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lwvo_pkg::CFG_SAMPLE_LENGTH: sample_length_reg <= cfg_data[lwvo_pkg::LEN_W-1:0];
                lwvo_pkg::CFG_LOOP_LENGTH:   loop_length_reg <= cfg_data[lwvo_pkg::LEN_W-1:0];
                lwvo_pkg::CFG_PING_PONG:     ping_pong_reg <= cfg_data[0];
                lwvo_pkg::CFG_SAMPLE_COUNT:  sample_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_sample)
            sample_mem[SAMPLE_ADDR_BITS'(address)] <= write_data;
        if (cmd.issue_rd)
            rd_data_reg <= sample_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_coef && (address < lwvo_pkg::ADDRESS_W'(COEF_DEPTH)))
            coef_mem[CAW'(address)] <= write_data[lwvo_pkg::COEF_W-1:0];
        if (cmd.coef_rd)
            coef_data_reg <= coef_mem[coef_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= '0;
            play_index_reg <= '0;
            first_seen_reg <= 1'b0;
            whole_reg      <= '0;
            flag_reg       <= 1'b0;
        end
        else if (cmd.start_tick)
        begin
            phase_reg <= phase_sum[lwvo_pkg::FRAC_W-1:0];
            whole_reg <= phase_sum[lwvo_pkg::PHASE_SUM_W-1:lwvo_pkg::FRAC_W];
            flag_reg  <= 1'b0;
        end
        else if (cmd.advance)
        begin
            if (!first_seen_reg && (play_ext >= e_reg))
            begin
                first_seen_reg <= 1'b1;
                flag_reg       <= 1'b1;
            end
            play_index_reg <= lwvo_pkg::PLAY_W'(step_index(play_ext, e_reg, s_reg));
            whole_reg      <= whole_reg - lwvo_pkg::WHOLE_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_tick)
        begin
            e_reg    <= e_calc;
            s_reg    <= s_calc;
            lim_reg  <= lim_calc[SAMPLE_ADDR_BITS-1:0];
            row_reg  <= row_prod[PW-1:lwvo_pkg::FRAC_W];
            walk_reg <= play_ext;
        end
        else if (cmd.issue_rd)
        begin
            walk_reg <= step_index(walk_reg, e_reg, s_reg);
        end

        if (cmd.capture)
        begin
            prev_reg <= rd_data_reg;
            if (cmd.cap_sel == 2'd0)
                acc_reg <= {{(lwvo_pkg::ACC_W - lwvo_pkg::DATA_W - lwvo_pkg::COEF_SHIFT)
                             {rd_data_reg[lwvo_pkg::DATA_W-1]}},
                            rd_data_reg, lwvo_pkg::COEF_SHIFT'(0)};
            else
                prod_reg <= coef_data_reg * diff;
        end

        if (cmd.accum)
            acc_reg <= acc_reg + {{(lwvo_pkg::ACC_W - lwvo_pkg::PROD_W)
                                   {prod_reg[lwvo_pkg::PROD_W-1]}}, prod_reg};

        if (cmd.finish)
            q_reg <= q_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            sample_out_reg <= q_reg;
            flag_out_reg   <= flag_reg;
        end
    end

    assign status.whole_zero = (whole_reg == '0);
    assign status.out_free   = !out_valid_reg || result_ready;
    assign result_valid      = out_valid_reg;
    assign sample_out        = sample_out_reg;
    assign first_run_done    = flag_out_reg;

endmodule

// ----- design/looped_wavetable_voice_oscillator.sv -----
`timescale 1ns / 1ps

// port      dir   transaction
// item      in    sample write, coefficient write or tick
// result    out   one interpolated sample and first-pass flag per tick
// cfg_*     in    register write, one per cycle with cfg_we high
//
// a write leaves item ready high; a tick drops ready until it is done, reading
// four taps over the single sample store port with one shared multiplier, then
// stepping the play index w times, w being the whole part of phase plus step
// (0 to 8). reset clears control and voice state; the stores are not cleared.
// a stalled result stays in the output register while the next item is taken.

module looped_wavetable_voice_oscillator #(
    parameter int SAMPLE_ADDR_BITS = 16,
    parameter int INTERP_STEPS     = 128
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lwvo_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lwvo_pkg::CFG_DATA_W-1:0]  cfg_data,
    lwvo_item_if.sink                        item,
    lwvo_result_if.source                    result
);

    lwvo_pkg::cmd_t    cmd;
    lwvo_pkg::status_t status;

    lwvo_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .operation  (item.operation),
        .item_ready (item.ready),
        .cmd        (cmd),
        .status     (status)
    );

    lwvo_datapath #(
        .SAMPLE_ADDR_BITS (SAMPLE_ADDR_BITS),
        .INTERP_STEPS     (INTERP_STEPS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .address        (item.address),
        .write_data     (item.write_data),
        .phase_step     (item.phase_step),
        .cmd            (cmd),
        .status         (status),
        .result_valid   (result.valid),
        .result_ready   (result.ready),
        .sample_out     (result.sample_out),
        .first_run_done (result.first_run_done)
    );

endmodule

// ----- design/lwvo_checker.sv -----
`timescale 1ns / 1ps

module lwvo_port_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             item_valid,
    input logic                             item_ready,
    input logic [lwvo_pkg::OPERATION_W-1:0] item_operation,
    input logic                             result_valid,
    input logic                             result_ready,
    input logic [lwvo_pkg::DATA_W-1:0]      sample_out,
    input logic                             first_run_done
);

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_operation == lwvo_pkg::OP_TICK) |=> !item_ready)
        else $error("ready stayed high after a tick transaction");

    a_write_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_operation != lwvo_pkg::OP_TICK) |=> item_ready)
        else $error("ready dropped after a write transaction");

    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> item_ready && !$past(item_ready))
        else $error("result appeared without a tick in progress");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(sample_out) && $stable(first_run_done))
        else $error("stalled result changed");

endmodule

bind looped_wavetable_voice_oscillator lwvo_port_checker u_lwvo_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .item_operation (item.operation),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .sample_out     (result.sample_out),
    .first_run_done (result.first_run_done)
);

// ----- test/lwvo_checker.sv -----
`timescale 1ns / 1ps

module lwvo_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lwvo_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lwvo_pkg::CFG_DATA_W-1:0]  cfg_data,
    lwvo_item_if                             item,
    lwvo_result_if                           result,
    output int                               fail_count,
    output int                               pending
);
    import lwvo_pkg::*;

    localparam int STORE_DEPTH = 65536;
    localparam int COEF_ROWS   = 128;
    localparam int COEF_DEPTH  = 3 * COEF_ROWS;

    typedef struct {
        logic signed [DATA_W-1:0] sample;
        logic                     flag;
    } voice_out_t;

    voice_out_t expected_samples[$];
    voice_out_t want;
    voice_out_t fresh;

    logic signed [DATA_W-1:0] wave_mem [0:STORE_DEPTH-1];
    logic signed [COEF_W-1:0] coef_mem [0:COEF_DEPTH-1];
    logic [FRAC_W-1:0]        phase_frac;
    logic signed [PLAY_W-1:0] play_pos;
    logic                     pass_seen;

    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   loop_reg;
    logic               pp_reg;
    logic [COUNT_W-1:0] count_reg;

    function automatic int wrap_step(int pos, int end_pos, int start_pos);
        return (pos + 1 > end_pos) ? start_pos : pos + 1;
    endfunction

    function automatic longint fetch_tap(int pos);
        int limit;
        limit = int'(count_reg);
        if (limit < 1)
            limit = 1;
        if (limit > STORE_DEPTH)
            limit = STORE_DEPTH;
        if (pos < 0)
            pos = 0;
        if (pos > limit - 1)
            pos = limit - 1;
        return longint'(wave_mem[pos]);
    endfunction

    function automatic void predict_voice_tick(input logic [STEP_W-1:0] step,
                                               output voice_out_t res);
        int                     end_pos;
        int                     start_pos;
        int                     pos;
        int                     whole;
        longint                 t0, t1, t2, t3;
        longint                 c0, c1, c2;
        longint                 acc, quo;
        logic [6:0]             row;
        logic [PHASE_SUM_W-1:0] sum;
        end_pos   = int'(len_reg) + (pp_reg ? int'(loop_reg) + 1 : 0);
        start_pos = int'(len_reg) - int'(loop_reg);
        pos = int'(play_pos);
        t0  = fetch_tap(pos);
        pos = wrap_step(pos, end_pos, start_pos);
        t1  = fetch_tap(pos);
        pos = wrap_step(pos, end_pos, start_pos);
        t2  = fetch_tap(pos);
        pos = wrap_step(pos, end_pos, start_pos);
        t3  = fetch_tap(pos);

        row = phase_frac[FRAC_W-1 -: 7];
        c0  = coef_mem[row];
        c1  = coef_mem[COEF_ROWS + row];
        c2  = coef_mem[2 * COEF_ROWS + row];

        acc = t0 * 4096 + c0 * (t1 - t0) + c1 * (t2 - t1) + c2 * (t3 - t2);
        quo = acc / 4096;
        if (quo > 32767)
            quo = 32767;
        if (quo < -32768)
            quo = -32768;

        sum        = phase_frac + step;
        whole      = int'(sum[PHASE_SUM_W-1:FRAC_W]);
        phase_frac = sum[FRAC_W-1:0];
        res.flag   = 1'b0;
        repeat (whole)
        begin
            if (!pass_seen && int'(play_pos) >= end_pos)
            begin
                pass_seen = 1'b1;
                res.flag  = 1'b1;
            end
            play_pos = PLAY_W'(wrap_step(int'(play_pos), end_pos, start_pos));
        end
        res.sample = quo[DATA_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_frac = '0;
            play_pos   = '0;
            pass_seen  = 1'b0;
            len_reg    = '0;
            loop_reg   = '0;
            pp_reg     = 1'b0;
            count_reg  = SAMPLE_COUNT_RESET;
            expected_samples.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SAMPLE_LENGTH: len_reg   = cfg_data[LEN_W-1:0];
                    CFG_LOOP_LENGTH:   loop_reg  = cfg_data[LEN_W-1:0];
                    CFG_PING_PONG:     pp_reg    = cfg_data[0];
                    CFG_SAMPLE_COUNT:  count_reg = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (result.valid && result.ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result at %0t: sample_out %0d first_run_done %0b",
                                 $time, result.sample_out, result.first_run_done);
                    fail_count++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (result.sample_out !== want.sample ||
                        result.first_run_done !== want.flag)
                    begin
                        if (fail_count < 10)
                            $display("mismatch at %0t: sample_out exp %0d got %0d, first_run_done exp %0b got %0b",
                                     $time, want.sample, result.sample_out,
                                     want.flag, result.first_run_done);
                        fail_count++;
                    end
                end
            end

            if (item.valid && item.ready)
            begin
                case (item.operation)
                    OP_WR_SAMPLE: wave_mem[item.address] = item.write_data;
                    OP_WR_COEF:
                    begin
                        if (item.address < COEF_DEPTH)
                            coef_mem[item.address] = item.write_data[COEF_W-1:0];
                    end
                    OP_TICK:
                    begin
                        predict_voice_tick(item.phase_step, fresh);
                        expected_samples.push_back(fresh);
                    end
                    default: ;
                endcase
            end

            pending <= expected_samples.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import lwvo_pkg::*;

    localparam logic [OPERATION_W-1:0] OP_UNUSED = 2'd3;

    localparam int STORE_DEPTH   = 65536;
    localparam int COEF_DEPTH    = 384;
    localparam int RANDOM_ITEMS  = 88;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;
    int prefix_words;
    int end_high;

    lwvo_item_if   item_ch();
    lwvo_result_if result_ch();

    looped_wavetable_voice_oscillator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    lwvo_checker voice_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item       (item_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [DATA_W-1:0] random_sample();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_coef();
        if ($urandom_range(3) == 0)
            return DATA_W'($urandom);
        return DATA_W'($urandom_range(8191) - 4096);
    endfunction

    task automatic send_item(input logic [OPERATION_W-1:0] op,
                             input logic [ADDRESS_W-1:0]   addr,
                             input logic [DATA_W-1:0]      data,
                             input logic [STEP_W-1:0]      step);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.operation  <= op;
        item_ch.address    <= addr;
        item_ch.write_data <= data;
        item_ch.phase_step <= step;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // words that a tap can reach get written before any tick reads them
    task automatic program_regs(input int len, input int loop_len, input int pp, input int count);
        int end_pos;
        int reach;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SAMPLE_LENGTH;
        cfg_data  <= CFG_DATA_W'(len);
        @(posedge clk);
        cfg_index <= CFG_LOOP_LENGTH;
        cfg_data  <= CFG_DATA_W'(loop_len);
        @(posedge clk);
        cfg_index <= CFG_PING_PONG;
        cfg_data  <= CFG_DATA_W'(pp);
        @(posedge clk);
        cfg_index <= CFG_SAMPLE_COUNT;
        cfg_data  <= CFG_DATA_W'(count);
        @(posedge clk);
        cfg_we <= 1'b0;

        end_pos = len + (pp != 0 ? loop_len + 1 : 0);
        if (end_pos > end_high)
            end_high = end_pos;
        reach = (count < 1) ? 1 : ((count > STORE_DEPTH) ? STORE_DEPTH : count);
        if (end_high + 1 < reach)
            reach = end_high + 1;
        while (prefix_words < reach)
        begin
            send_item(OP_WR_SAMPLE, ADDRESS_W'(prefix_words), random_sample(), STEP_W'($urandom));
            prefix_words++;
        end
        item_ch.valid <= 1'b0;
    endtask

    task automatic random_burst(input int quota);
        int                     done;
        int                     pick;
        logic [ADDRESS_W-1:0]   addr;
        logic [STEP_W-1:0]      step;
        done = 0;
        while (done < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 62)
            begin
                case ($urandom_range(3))
                    0:       step = STEP_W'($urandom_range(16'hFFFF));
                    1:       step = STEP_W'($urandom);
                    default: step = STEP_W'($urandom_range(20'h1FFFF));
                endcase
                send_item(OP_TICK, ADDRESS_W'($urandom), DATA_W'($urandom), step);
                done++;
            end
            else if (pick < 80)
            begin
                send_item(OP_WR_SAMPLE, ADDRESS_W'($urandom), random_sample(),
                          STEP_W'($urandom));
                done++;
            end
            else if (pick < 95)
            begin
                if ($urandom_range(7) == 0)
                    addr = ADDRESS_W'($urandom);
                else
                    addr = ADDRESS_W'($urandom_range(COEF_DEPTH - 1));
                send_item(OP_WR_COEF, addr, random_coef(), STEP_W'($urandom));
                if (addr < COEF_DEPTH)
                    done++;
            end
            else
            begin
                send_item(OP_UNUSED, ADDRESS_W'($urandom), DATA_W'($urandom),
                          STEP_W'($urandom));
            end
        end
        item_ch.valid <= 1'b0;
    endtask

    task automatic drain_results();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic change_setting(input int len, input int loop_len, input int pp,
                                  input int count, input int tx_pct, input int rx_pct);
        drain_results();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        program_regs(len, loop_len, pp, count);
        random_burst(RANDOM_ITEMS);
    endtask

    initial
    begin
        tx_idle_pct  = 31;
        rx_idle_pct  = 50;
        prefix_words = 0;
        end_high     = 0;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        item_ch.valid      <= 1'b0;
        item_ch.operation  <= OP_WR_SAMPLE;
        item_ch.address    <= '0;
        item_ch.write_data <= '0;
        item_ch.phase_step <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_regs(40, 16, 0, 65536);
        for (int a = 0; a < COEF_DEPTH; a++)
            send_item(OP_WR_COEF, ADDRESS_W'(a), random_coef(), '0);

        send_item(OP_WR_SAMPLE, 16'hFFFF, 16'h8000, '0);
        send_item(OP_WR_SAMPLE, 16'h8000, 16'h7FFF, 19'h7FFFF);
        send_item(OP_WR_SAMPLE, 16'd1, 16'h7FFF, '0);
        send_item(OP_WR_SAMPLE, 16'd2, 16'h8000, '0);
        send_item(OP_WR_COEF, 16'd383, 16'h7FFF, '0);
        send_item(OP_WR_COEF, 16'd0, 16'h1FFF, '0);
        send_item(OP_WR_COEF, 16'd128, 16'h2000, '0);
        // coefficient writes past the third table are dropped
        send_item(OP_WR_COEF, 16'd384, 16'h1234, '0);
        send_item(OP_WR_COEF, 16'hFFFF, 16'hFFFF, '0);
        send_item(OP_UNUSED, 16'hFFFF, 16'h8000, 19'h7FFFF);
        send_item(OP_TICK, 16'hFFFF, 16'hFFFF, 19'd0);
        send_item(OP_TICK, '0, '0, 19'h7FFFF);
        send_item(OP_TICK, '0, '0, 19'h10000);
        send_item(OP_TICK, '0, '0, 19'h0FFFF);
        send_item(OP_TICK, '0, '0, 19'h00001);
        send_item(OP_TICK, '0, '0, 19'h40000);
        random_burst(RANDOM_ITEMS);

        change_setting(30, 30, 1, 20, 31, 50);
        change_setting(10, 25, 0, 0, 31, 50);
        change_setting(100, 0, 0, 'h1FFFF, 50, 31);
        change_setting(0, 0, 1, 50, 50, 31);
        change_setting(64, 65535, 0, 80, 50, 31);
        change_setting(65535, 65535, 1, 8, 0, 0);
        change_setting(65535, 3, 0, 1, 0, 0);
        change_setting(20, 5, 0, 30, 0, 0);

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
